// ===== hw/rtl/kufs_pkg.sv =====
`timescale 1ns / 1ps

package kufs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int SRC_W        = 6;
  localparam int WEIGHT_W     = 16;
  localparam int TOTAL_W      = 32;
  localparam int RANK_W       = 3;

  // only indexes below 64 can ever be reached from a 6-bit edge end
  localparam int VTX_DEPTH = (MAX_VERTICES < (1 << SRC_W)) ? MAX_VERTICES : (1 << SRC_W);
  localparam int VW        = $clog2(VTX_DEPTH);

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef logic [VW-1:0]     vtx_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    vtx_t  parent;
    rank_t rank;
  } entry_t;

  typedef struct packed {
    logic   en;
    vtx_t   addr;
    entry_t data;
  } store_wr_t;

  typedef struct packed {
    logic                new_run;
    logic [SRC_W-1:0]    edge_src;
    logic [SRC_W-1:0]    edge_dst;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic               taken;
    logic [TOTAL_W-1:0] tree_weight;
  } out_item_t;

endpackage

// ===== hw/rtl/kufs_store.sv =====
`timescale 1ns / 1ps

module kufs_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  kufs_pkg::vtx_t      rd_addr,
  output kufs_pkg::entry_t    rd_data,
  input  kufs_pkg::store_wr_t wr
);
  import kufs_pkg::*;

  entry_t               mem [VTX_DEPTH];
  logic [VTX_DEPTH-1:0] valid_r;
  entry_t               rdata_r;
  logic                 rvalid_r;
  vtx_t                 raddr_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[rd_addr];
    raddr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rvalid_r <= valid_r[rd_addr];
    end
  end

  // unwritten entries read as their reset value: own index, rank zero
  always_comb begin
    if (rvalid_r) begin
      rd_data = rdata_r;
    end else begin
      rd_data.parent = raddr_r;
      rd_data.rank   = '0;
    end
  end

endmodule

// ===== hw/rtl/kruskal_union_find_step.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_ready   in_data  (new_run, edge_src, edge_dst, edge_weight)
// out      out  out_valid/out_ready out_data (taken, tree_weight)
//
// One edge at a time: accept, then S_START and S_WALK for each end to find its root,
// S_COMP to compress a path that did not start at the root, S_DECIDE, S_BUMP on a rank
// tie, and S_DONE; the block returns to idle before the next accept. An edge with an
// end out of range goes straight to S_DONE. The single store port walks both chains.
// Reset and new_run clear the store valid bits at once; no clearing pass.
// The next edge is taken while a result waits; a finished edge holds until out is free.

module kruskal_union_find_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kufs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kufs_pkg::out_item_t out_data
);
  import kufs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_COMP   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_BUMP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  vtx_t                cur_r, cur_nxt;
  vtx_t                start_r, start_nxt;
  vtx_t                dst_r, dst_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                side_r, side_nxt;
  vtx_t                root_s_r, root_s_nxt;
  vtx_t                root_d_r, root_d_nxt;
  rank_t               rank_s_r, rank_s_nxt;
  rank_t               rank_d_r, rank_d_nxt;
  logic                taken_r, taken_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic                clr;
  vtx_t                rd_addr;
  entry_t              rdata;
  store_wr_t           wr;
  logic                out_load;
  logic                in_range;
  vtx_t                root_cur;
  logic [TOTAL_W:0]    sum;

  kufs_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .rd_addr (rd_addr),
    .rd_data (rdata),
    .wr      (wr)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_range = (int'(in_data.edge_src) < MAX_VERTICES) &&
                    (int'(in_data.edge_dst) < MAX_VERTICES);
  assign root_cur = side_r ? root_d_r : root_s_r;
  assign sum      = {1'b0, total_r} + (TOTAL_W + 1)'(weight_r);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    start_nxt  = start_r;
    dst_nxt    = dst_r;
    weight_nxt = weight_r;
    side_nxt   = side_r;
    root_s_nxt = root_s_r;
    root_d_nxt = root_d_r;
    rank_s_nxt = rank_s_r;
    rank_d_nxt = rank_d_r;
    taken_nxt  = taken_r;
    total_nxt  = total_r;
    clr        = 1'b0;
    rd_addr    = cur_r;
    wr         = '0;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          clr        = in_data.new_run;
          total_nxt  = in_data.new_run ? '0 : total_r;
          start_nxt  = VW'(in_data.edge_src);
          cur_nxt    = VW'(in_data.edge_src);
          dst_nxt    = VW'(in_data.edge_dst);
          weight_nxt = in_data.edge_weight;
          side_nxt   = 1'b0;
          taken_nxt  = 1'b0;
          state_nxt  = in_range ? S_START : S_DONE;
        end
      end
      S_START: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (rdata.parent == cur_r) begin
          if (side_r) begin
            root_d_nxt = cur_r;
            rank_d_nxt = rdata.rank;
          end else begin
            root_s_nxt = cur_r;
            rank_s_nxt = rdata.rank;
          end
          if (cur_r != start_r) begin
            cur_nxt   = start_r;
            rd_addr   = start_r;
            state_nxt = S_COMP;
          end else if (!side_r) begin
            side_nxt  = 1'b1;
            start_nxt = dst_r;
            cur_nxt   = dst_r;
            state_nxt = S_START;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          cur_nxt = rdata.parent;
          rd_addr = rdata.parent;
        end
      end
      S_COMP: begin
        wr.en          = 1'b1;
        wr.addr        = cur_r;
        wr.data.parent = root_cur;
        wr.data.rank   = rdata.rank;
        if (rdata.parent != root_cur) begin
          cur_nxt = rdata.parent;
          rd_addr = rdata.parent;
        end else if (!side_r) begin
          side_nxt  = 1'b1;
          start_nxt = dst_r;
          cur_nxt   = dst_r;
          state_nxt = S_START;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (root_s_r != root_d_r) begin
          taken_nxt = 1'b1;
          total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          wr.en     = 1'b1;
          if (rank_s_r < rank_d_r) begin
            wr.addr        = root_s_r;
            wr.data.parent = root_d_r;
            wr.data.rank   = rank_s_r;
          end else begin
            wr.addr        = root_d_r;
            wr.data.parent = root_s_r;
            wr.data.rank   = rank_d_r;
            if (rank_s_r == rank_d_r) begin
              state_nxt = S_BUMP;
            end
          end
        end
      end
      S_BUMP: begin
        wr.en          = 1'b1;
        wr.addr        = root_s_r;
        wr.data.parent = root_s_r;
        wr.data.rank   = (rank_s_r == RANK_MAX) ? rank_s_r : rank_t'(rank_s_r + 1'b1);
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    dst_r    <= dst_nxt;
    weight_r <= weight_nxt;
    side_r   <= side_nxt;
    root_s_r <= root_s_nxt;
    root_d_r <= root_d_nxt;
    rank_s_r <= rank_s_nxt;
    rank_d_r <= rank_d_nxt;
    taken_r  <= taken_nxt;
    if (out_load) begin
      out_data_r.taken       <= taken_r;
      out_data_r.tree_weight <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/kruskal_union_find_step_tb.sv =====
`timescale 1ns / 1ps

class forest_scoreboard;
  kufs_pkg::vtx_t                    parent_of[kufs_pkg::MAX_VERTICES];
  kufs_pkg::rank_t                   rank_of[kufs_pkg::MAX_VERTICES];
  logic [kufs_pkg::TOTAL_W-1:0]      tree_total;
  kufs_pkg::out_item_t               expected_q[$];
  int                                errors;

  function new();
    errors = 0;
    clear_forest();
  endfunction

  function void clear_forest();
    for (int v = 0; v < kufs_pkg::MAX_VERTICES; v++) begin
      parent_of[v] = kufs_pkg::vtx_t'(v);
      rank_of[v]   = '0;
    end
    tree_total = '0;
  endfunction

  // root lookup; every node on the walked path is pointed at the root
  function int unsigned root_of(int unsigned v);
    int unsigned root;
    int unsigned cur;
    int unsigned nxt;
    int steps;
    root  = v;
    steps = 0;
    while (steps < kufs_pkg::MAX_VERTICES && int'(parent_of[root]) != root) begin
      root = 32'(parent_of[root]);
      steps++;
    end
    cur   = v;
    steps = 0;
    while (cur != root && steps < kufs_pkg::MAX_VERTICES) begin
      nxt = 32'(parent_of[cur]);
      parent_of[cur] = kufs_pkg::vtx_t'(root);
      cur = nxt;
      steps++;
    end
    return root;
  endfunction

  function void note_edge(kufs_pkg::in_item_t e);
    int unsigned rs;
    int unsigned rd;
    logic [kufs_pkg::TOTAL_W:0] sum;
    kufs_pkg::out_item_t res;
    if (e.new_run) clear_forest();
    res.taken = 1'b0;
    rs = root_of(32'(e.edge_src));
    rd = root_of(32'(e.edge_dst));
    if (rs != rd) begin
      sum = {1'b0, tree_total} + e.edge_weight;
      tree_total = sum[kufs_pkg::TOTAL_W] ? '1 : sum[kufs_pkg::TOTAL_W-1:0];
      if (rank_of[rs] < rank_of[rd]) begin
        parent_of[rs] = kufs_pkg::vtx_t'(rd);
      end else if (rank_of[rs] > rank_of[rd]) begin
        parent_of[rd] = kufs_pkg::vtx_t'(rs);
      end else begin
        parent_of[rd] = kufs_pkg::vtx_t'(rs);
        if (rank_of[rs] != kufs_pkg::RANK_MAX) rank_of[rs] = rank_of[rs] + 1'b1;
      end
      res.taken = 1'b1;
    end
    res.tree_weight = tree_total;
    expected_q.push_back(res);
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task check(kufs_pkg::out_item_t got);
    kufs_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected transaction taken=%0b tree_weight=%0d",
                       got.taken, got.tree_weight));
    end else begin
      exp = expected_q.pop_front();
      if (got.taken !== exp.taken)
        report($sformatf("taken %0b, expected %0b", got.taken, exp.taken));
      if (got.tree_weight !== exp.tree_weight)
        report($sformatf("tree_weight %0d, expected %0d", got.tree_weight, exp.tree_weight));
    end
  endtask

  function int waiting();
    return expected_q.size();
  endfunction
endclass

module kruskal_union_find_step_tb;
  import kufs_pkg::*;

  localparam int NUM_EDGES = 1350;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int  send_idle = 0;
  int  recv_idle = 0;
  int  sent = 0;
  int  hold_reqs = 0;
  forest_scoreboard sb;

  kruskal_union_find_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk_edge(bit nr, int unsigned s, int unsigned d, int unsigned w);
    in_item_t e;
    e.new_run     = nr;
    e.edge_src    = SRC_W'(s);
    e.edge_dst    = SRC_W'(d);
    e.edge_weight = WEIGHT_W'(w);
    return e;
  endfunction

  task automatic send_edge(in_item_t e);
    int phase;
    phase = sent * 3 / NUM_EDGES;
    if (phase == 0) begin
      send_idle = 16;
      recv_idle = 64;
    end else if (phase == 1) begin
      send_idle = 64;
      recv_idle = 16;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (sent == 300 || sent == 1000) hold_reqs++;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    do @(posedge clk); while (!in_ready);
    sb.note_edge(e);
    sent++;
  endtask

  // receiver; a long hold-off fills the block and stalls its input
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  initial begin
    in_item_t e;
    int kind;
    int run_len;
    int nv;
    int base;
    int unsigned w;
    int i;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edge(mk_edge(1, 0, 63, 0));
    send_edge(mk_edge(0, 63, 0, 0));
    send_edge(mk_edge(0, 5, 5, 1));
    send_edge(mk_edge(0, 1, 2, 1));
    send_edge(mk_edge(0, 2, 3, 2));
    send_edge(mk_edge(0, 3, 4, 3));
    send_edge(mk_edge(0, 4, 1, 4));
    send_edge(mk_edge(0, 10, 11, 5));
    send_edge(mk_edge(0, 12, 13, 5));
    send_edge(mk_edge(0, 10, 12, 6));
    send_edge(mk_edge(0, 11, 13, 7));
    send_edge(mk_edge(0, 1, 13, 8));
    send_edge(mk_edge(0, 4, 11, 9));
    send_edge(mk_edge(0, 0, 4, 100));
    send_edge(mk_edge(0, 21, 42, 16'h5555));
    send_edge(mk_edge(0, 42, 21, 16'hAAAA));
    send_edge(mk_edge(0, 62, 61, 65535));
    send_edge(mk_edge(0, 0, 62, 65535));
    send_edge(mk_edge(0, 61, 63, 65535));
    send_edge(mk_edge(1, 63, 63, 65535));
    send_edge(mk_edge(0, 63, 0, 65535));
    send_edge(mk_edge(1, 32, 31, 1));

    while (sent < NUM_EDGES) begin
      kind    = $urandom_range(9);
      run_len = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 120);
      nv      = ($urandom_range(3) == 0) ? 64 : $urandom_range(2, 40);
      base    = $urandom_range(0, 64 - nv);
      w       = $urandom_range(1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
      for (i = 0; i < run_len && sent < NUM_EDGES; i++) begin
        if (kind == 0) begin
          e = mk_edge($urandom_range(7) == 0, $urandom_range(63), $urandom_range(63),
                      $urandom_range(65535));
        end else begin
          e = mk_edge(i == 0 && kind != 1, base + $urandom_range(nv - 1),
                      base + $urandom_range(nv - 1), w);
          w = w + $urandom_range(0, 1 << $urandom_range(11));
          if (w > 65535) w = 65535;
        end
        send_edge(e);
      end
    end
    in_valid <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("kruskal_union_find_step_tb OK");
    end else begin
      $display("kruskal_union_find_step_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("kruskal_union_find_step_tb NOT OK");
    $finish;
  end

endmodule
